// File: design/pnt_pkg.sv
// Shared types, constants and the control store for the perfect number test unit.
// Used by every module of the block but pnt_div; depends on nothing else.
package pnt_pkg;

   localparam int DEF_VALUE_WIDTH = 32;
   localparam int NUMBER_WIDTH    = 32;
   localparam int STEP_WIDTH      = 4;

   typedef enum logic [STEP_WIDTH-1:0] {
      S_IDLE       = 4'd0,
      S_CHECK      = 4'd1,
      S_DIV        = 4'd2,
      S_WAIT       = 4'd3,
      S_BOUND      = 4'd4,
      S_REM_TEST   = 4'd5,
      S_ADD_I      = 4'd6,
      S_SUM_TEST_I = 4'd7,
      S_Q_TEST     = 4'd8,
      S_ADD_Q      = 4'd9,
      S_SUM_TEST_Q = 4'd10,
      S_NEXT       = 4'd11,
      S_WAIT_OUT   = 4'd12,
      S_EMIT       = 4'd13
   } step_type;

   typedef enum logic [3:0] {
      COND_NEVER    = 4'd0,
      COND_ALWAYS   = 4'd1,
      COND_NO_REQ   = 4'd2,
      COND_SMALL    = 4'd3,
      COND_DIV_BUSY = 4'd4,
      COND_I_GT_Q   = 4'd5,
      COND_REM_NZ   = 4'd6,
      COND_SUM_GT   = 4'd7,
      COND_Q_EQ_I   = 4'd8,
      COND_OUT_BUSY = 4'd9
   } cond_type;

   typedef struct packed {
      logic     req_ready;
      logic     init;
      logic     div_start;
      logic     add_i;
      logic     add_q;
      logic     inc_i;
      logic     emit;
      cond_type cond;
      step_type target;
   } ctrl_type;

   typedef struct packed {
      logic small_value;
      logic div_busy;
      logic i_gt_q;
      logic rem_nz;
      logic sum_gt;
      logic q_eq_i;
      logic out_busy;
   } stat_type;

   // Control store: one word per step. A true condition jumps to the target,
   // otherwise the sequencer moves on to the next step.
   function automatic ctrl_type ucode(input step_type step);
      ctrl_type w;
      begin
         w = '0;
         w.cond = COND_NEVER;
         w.target = S_IDLE;
         case (step)
            S_IDLE: begin
               w.req_ready = 1'b1;
               w.cond = COND_NO_REQ;
               w.target = S_IDLE;
            end
            S_CHECK: begin
               w.init = 1'b1;
               w.cond = COND_SMALL;
               w.target = S_WAIT_OUT;
            end
            S_DIV: begin
               w.div_start = 1'b1;
            end
            S_WAIT: begin
               w.cond = COND_DIV_BUSY;
               w.target = S_WAIT;
            end
            S_BOUND: begin
               w.cond = COND_I_GT_Q;
               w.target = S_WAIT_OUT;
            end
            S_REM_TEST: begin
               w.cond = COND_REM_NZ;
               w.target = S_NEXT;
            end
            S_ADD_I: begin
               w.add_i = 1'b1;
            end
            S_SUM_TEST_I: begin
               w.cond = COND_SUM_GT;
               w.target = S_WAIT_OUT;
            end
            S_Q_TEST: begin
               w.cond = COND_Q_EQ_I;
               w.target = S_NEXT;
            end
            S_ADD_Q: begin
               w.add_q = 1'b1;
            end
            S_SUM_TEST_Q: begin
               w.cond = COND_SUM_GT;
               w.target = S_WAIT_OUT;
            end
            S_NEXT: begin
               w.inc_i = 1'b1;
               w.cond = COND_ALWAYS;
               w.target = S_DIV;
            end
            S_WAIT_OUT: begin
               w.cond = COND_OUT_BUSY;
               w.target = S_WAIT_OUT;
            end
            S_EMIT: begin
               w.emit = 1'b1;
               w.cond = COND_ALWAYS;
               w.target = S_IDLE;
            end
            default: begin
               w.cond = COND_ALWAYS;
               w.target = S_IDLE;
            end
         endcase
         return w;
      end
   endfunction

endpackage

// File: design/pnt_div.sv
// Restoring divider that produces one quotient bit per cycle.
// Uses no package items; instantiated by the datapath.
module pnt_div #(
   parameter int WIDTH = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [WIDTH-1:0] dividend,
   input  logic [WIDTH-1:0] divisor,
   output logic             busy,
   output logic [WIDTH-1:0] quotient,
   output logic [WIDTH-1:0] remainder
);

   localparam int CNT_W = $clog2(WIDTH + 1);

   logic             busy_ff, busy_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [WIDTH-1:0] quo_ff, quo_in;
   logic [WIDTH-1:0] rem_ff, rem_in;
   logic [WIDTH-1:0] dvs_ff, dvs_in;
   logic [WIDTH:0]   trial;
   logic [WIDTH:0]   diff;
   logic             fits;

   always_comb begin
      trial = {rem_ff, quo_ff[WIDTH-1]};
      diff = trial - {1'b0, dvs_ff};
      fits = trial >= {1'b0, dvs_ff};
      busy_in = busy_ff;
      cnt_in = cnt_ff;
      quo_in = quo_ff;
      rem_in = rem_ff;
      dvs_in = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in = CNT_W'(WIDTH);
         quo_in = dividend;
         rem_in = '0;
         dvs_in = divisor;
      end else if (busy_ff) begin
         quo_in = {quo_ff[WIDTH-2:0], fits};
         rem_in = fits ? diff[WIDTH-1:0] : trial[WIDTH-1:0];
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign busy = busy_ff;
   assign quotient = quo_ff;
   assign remainder = rem_ff;

`ifndef SYNTH
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff)
      else $error("divider started while busy");

   a_rem_below_divisor: assert property (@(posedge clock) disable iff (reset)
      $fell(busy_ff) |-> (rem_ff < dvs_ff))
      else $error("remainder not below divisor");
`endif

endmodule

// File: design/pnt_dp.sv
// Datapath: number, trial divisor, divisor sum, divider and result register.
// Depends on pnt_pkg and pnt_div.
module pnt_dp #(
   parameter int VALUE_WIDTH = pnt_pkg::DEF_VALUE_WIDTH
) (
   input  logic                            clock,
   input  logic                            reset,
   input  pnt_pkg::ctrl_type               ctrl,
   input  logic                            req_valid,
   input  logic [pnt_pkg::NUMBER_WIDTH-1:0] req_number,
   input  logic                            rsp_stall,
   output logic                            rsp_valid,
   output logic                            rsp_is_perfect,
   output pnt_pkg::stat_type               stat
);

   logic [VALUE_WIDTH-1:0] n_ff, n_in;
   logic [VALUE_WIDTH-1:0] i_ff, i_in;
   logic [VALUE_WIDTH:0]   sum_ff, sum_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_is_perfect_ff, rsp_is_perfect_in;
   logic                   div_busy;
   logic [VALUE_WIDTH-1:0] quotient;
   logic [VALUE_WIDTH-1:0] remainder;
   logic                   small_value;

   pnt_div #(
      .WIDTH(VALUE_WIDTH)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (ctrl.div_start),
      .dividend (n_ff),
      .divisor  (i_ff),
      .busy     (div_busy),
      .quotient (quotient),
      .remainder(remainder)
   );

   always_comb begin
      small_value = n_ff[VALUE_WIDTH-1] || (n_ff <= VALUE_WIDTH'(1));
      n_in = n_ff;
      i_in = i_ff;
      sum_in = sum_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_is_perfect_in = rsp_is_perfect_ff;
      if (ctrl.req_ready && req_valid) begin
         n_in = VALUE_WIDTH'($unsigned(req_number));
      end
      if (ctrl.init) begin
         i_in = VALUE_WIDTH'(2);
         sum_in = (VALUE_WIDTH + 1)'(1);
      end
      if (ctrl.add_i) begin
         sum_in = sum_ff + {1'b0, i_ff};
      end
      if (ctrl.add_q) begin
         sum_in = sum_ff + {1'b0, quotient};
      end
      if (ctrl.inc_i) begin
         i_in = i_ff + VALUE_WIDTH'(1);
      end
      if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (ctrl.emit) begin
         rsp_valid_in = 1'b1;
         rsp_is_perfect_in = (sum_ff == {1'b0, n_ff}) && !small_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      n_ff <= n_in;
      i_ff <= i_in;
      sum_ff <= sum_in;
      rsp_is_perfect_ff <= rsp_is_perfect_in;
   end

   always_comb begin
      stat.small_value = small_value;
      stat.div_busy = div_busy;
      stat.i_gt_q = i_ff > quotient;
      stat.rem_nz = remainder != '0;
      stat.sum_gt = sum_ff > {1'b0, n_ff};
      stat.q_eq_i = quotient == i_ff;
      stat.out_busy = rsp_valid_ff && rsp_stall;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_is_perfect = rsp_is_perfect_ff;

endmodule

// File: design/pnt_seq.sv
// Microcode sequencer: step counter, control store lookup and conditional jumps.
// Depends on pnt_pkg for the step, condition and control word types.
module pnt_seq (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  pnt_pkg::stat_type stat,
   output pnt_pkg::ctrl_type ctrl
);

   pnt_pkg::step_type                step_ff, step_in;
   logic [pnt_pkg::STEP_WIDTH-1:0]   step_seq;
   logic                             jump;

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= pnt_pkg::S_IDLE;
      end else begin
         step_ff <= step_in;
      end
   end

   always_comb begin
      ctrl = pnt_pkg::ucode(step_ff);
      case (ctrl.cond)
         pnt_pkg::COND_NEVER:    jump = 1'b0;
         pnt_pkg::COND_ALWAYS:   jump = 1'b1;
         pnt_pkg::COND_NO_REQ:   jump = !req_valid;
         pnt_pkg::COND_SMALL:    jump = stat.small_value;
         pnt_pkg::COND_DIV_BUSY: jump = stat.div_busy;
         pnt_pkg::COND_I_GT_Q:   jump = stat.i_gt_q;
         pnt_pkg::COND_REM_NZ:   jump = stat.rem_nz;
         pnt_pkg::COND_SUM_GT:   jump = stat.sum_gt;
         pnt_pkg::COND_Q_EQ_I:   jump = stat.q_eq_i;
         pnt_pkg::COND_OUT_BUSY: jump = stat.out_busy;
         default:                jump = 1'b1;
      endcase
      step_seq = step_ff + pnt_pkg::STEP_WIDTH'(1);
      step_in = jump ? ctrl.target : pnt_pkg::step_type'(step_seq);
   end

`ifndef SYNTH
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      (step_ff == pnt_pkg::S_EMIT) |-> !stat.out_busy)
      else $error("result written while the output register is held");

   a_bound_after_div: assert property (@(posedge clock) disable iff (reset)
      (step_ff == pnt_pkg::S_BOUND) |-> !stat.div_busy)
      else $error("quotient used before the divider finished");
`endif

endmodule

// File: design/perfect_number_test_unit.sv
// Top level of the perfect number test unit: sequencer plus datapath.
// Depends on pnt_pkg, pnt_seq, pnt_dp and pnt_div.
//
// The request channel (req_valid, req_stall, req_number) takes one signed
// number per item. Only the low VALUE_WIDTH bits are tested, read as a two's
// complement value. The response channel (rsp_valid, rsp_stall,
// rsp_is_perfect) returns one bit per item, in order.
// The block works on one item at a time. A value below 2, negative ones
// included, skips the divider: after the check step it waits for the output
// register and is written by the emit step, and the sequencer then returns to
// idle for the next item. Otherwise every trial divisor i with i*i <= n costs
// one pass of the bit-serial divider plus the microcode steps that test and add
// i and n/i; the divider sets the time per item.
// A new item is accepted as soon as the previous result sits in the output
// register, even while the receiver stalls it. The next result waits in its
// step before the emit step until the register is free, so a stalled result never changes.
// Synchronous reset returns the sequencer to its idle step and clears
// rsp_valid; no item in flight survives it.
module perfect_number_test_unit #(
   parameter int VALUE_WIDTH = pnt_pkg::DEF_VALUE_WIDTH
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [pnt_pkg::NUMBER_WIDTH-1:0] req_number,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic                             rsp_is_perfect
);

   pnt_pkg::ctrl_type ctrl;
   pnt_pkg::stat_type stat;

   pnt_seq u_seq (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .stat     (stat),
      .ctrl     (ctrl)
   );

   pnt_dp #(
      .VALUE_WIDTH(VALUE_WIDTH)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .ctrl          (ctrl),
      .req_valid     (req_valid),
      .req_number    (req_number),
      .rsp_stall     (rsp_stall),
      .rsp_valid     (rsp_valid),
      .rsp_is_perfect(rsp_is_perfect),
      .stat          (stat)
   );

   assign req_stall = !ctrl.req_ready;

endmodule

// File: verif/tb_perfect_number_test_unit.sv
`timescale 1ns / 100ps
// Self-checking testbench for perfect_number_test_unit: directed and random numbers,
// idle and stall phases, and one long receiver hold-off. Needs pnt_pkg and the block.
class perfect_scoreboard;
   localparam int WIDTH = pnt_pkg::DEF_VALUE_WIDTH;

   bit pending_verdicts[$];
   int errors = 0;

   function automatic bit perfect_number_of(logic [pnt_pkg::NUMBER_WIDTH-1:0] raw);
      longint unsigned n;
      longint unsigned acc;
      longint unsigned i;
      longint unsigned q;
      n = 64'(raw);
      if (WIDTH < 64) n = n & ((64'd1 << WIDTH) - 64'd1);
      if (n[WIDTH-1]) return 1'b0;
      if (n <= 1) return 1'b0;
      acc = 1;
      for (i = 2; i <= n / i; i++) begin
         if (n % i == 0) begin
            q = n / i;
            acc += i;
            if (acc > n) return 1'b0;
            if (q != i) begin
               acc += q;
               if (acc > n) return 1'b0;
            end
         end
      end
      return acc == n;
   endfunction

   task report(string what);
      $display("MISMATCH at %0t: %s", $time, what);
      errors++;
   endtask

   function void note_number(logic [pnt_pkg::NUMBER_WIDTH-1:0] number);
      pending_verdicts.push_back(perfect_number_of(number));
   endfunction

   task check_verdict(logic got);
      bit want;
      if (pending_verdicts.size() == 0) begin
         report($sformatf("result %0b with no item outstanding", got));
      end else begin
         want = pending_verdicts.pop_front();
         if (got !== want) report($sformatf("is_perfect %0b, expected %0b", got, want));
      end
   endtask
endclass

module tb_perfect_number_test_unit;
   localparam int VALUE_WIDTH = pnt_pkg::DEF_VALUE_WIDTH;
   localparam int QUIET_LIMIT = 1500000;
   localparam int N_DIRECTED = 22;
   localparam logic [31:0] DIRECTED_NUMBERS [N_DIRECTED] = '{
      32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd6, 32'd12, 32'd16, 32'd25, 32'd28, 32'd97,
      32'd496, 32'd945, 32'd8127, 32'd8128, 32'd8129, 32'd1000003, 32'd33550336,
      32'h7FFFFFF8, 32'h55555554, 32'h80000000, 32'hFFFFFFFA
   };

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [31:0] req_number;
   logic        rsp_valid;
   logic        rsp_stall;
   logic        rsp_is_perfect;

   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int stall_hold    = 0;
   int quiet_cycles  = 0;

   perfect_scoreboard sb = new;

   perfect_number_test_unit #(
      .VALUE_WIDTH(VALUE_WIDTH)
   ) i_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_number    (req_number),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_is_perfect(rsp_is_perfect)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // The receiver side: a counted hold-off takes priority over random stalls.
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_hold > 0) begin
            rsp_stall = 1'b1;
            stall_hold--;
         end else begin
            rsp_stall = ($urandom_range(0, 99) < rsp_stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check_verdict(rsp_is_perfect);
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("perfect_number_test_unit verification failed");
         $finish;
      end
   end

   function automatic logic [31:0] pick_number();
      int unsigned kind;
      int unsigned bits;
      kind = $urandom_range(0, 9);
      bits = $urandom_range(1, 14);
      case (kind)
         0, 1, 2: begin
            return {1'b1, 31'($urandom)};
         end
         3, 4, 5: begin
            return $urandom & ((32'd1 << bits) - 32'd1);
         end
         6, 7: begin
            return 32'($urandom_range(1, 178956970)) * 32'd12;
         end
         8: begin
            case ($urandom_range(0, 3))
               0: return 32'd6;
               1: return 32'd28;
               2: return 32'd496;
               default: return 32'd8128;
            endcase
         end
         default: begin
            return 32'($urandom_range(0, 2));
         end
      endcase
   endfunction

   // Called at a falling edge; returns at the falling edge after the item is taken.
   task automatic send_number(input logic [31:0] value);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid = 1'b0;
         req_number = $urandom;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_number = value;
      do @(posedge clock); while (req_stall);
      sb.note_number(value);
      @(negedge clock);
   endtask

   task automatic run_phase(input int idle_pct, input int stall_pct, input int count);
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      repeat (count) send_number(pick_number());
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_number = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      for (int k = 0; k < N_DIRECTED; k++) send_number(DIRECTED_NUMBERS[k]);

      run_phase(0, 0, 18);
      run_phase(49, 0, 18);
      run_phase(0, 49, 18);
      run_phase(27, 27, 18);

      // The receiver holds off while small items keep coming, so the block backs up.
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      stall_hold = 500;
      repeat (8) send_number($urandom_range(0, 255));

      req_valid = 1'b0;
      while (sb.pending_verdicts.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);

      if (sb.errors == 0 && sb.pending_verdicts.size() == 0) begin
         $display("perfect_number_test_unit verification clean");
      end else begin
         $display("perfect_number_test_unit verification failed");
      end
      $finish;
   end
endmodule

// File: filelist.f
design/pnt_pkg.sv
design/pnt_div.sv
design/pnt_dp.sv
design/pnt_seq.sv
design/perfect_number_test_unit.sv
verif/tb_perfect_number_test_unit.sv
